// ----- design/wcrc_pkg.sv -----
package wcrc_pkg;

    localparam int MAX_ROW_WIDTH = 16;
    localparam int PosW = $clog2(MAX_ROW_WIDTH + 3);
    localparam int IdxW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int QBits = 64;

    localparam logic [0:0] CfgMode = 1'b0;
    localparam logic [0:0] CfgWidth = 1'b1;

    localparam logic [2:0] StClean = 3'd0;
    localparam logic [2:0] StData = 3'd1;
    localparam logic [2:0] StPlain = 3'd2;
    localparam logic [2:0] StWeighted = 3'd3;
    localparam logic [2:0] StBad = 3'd4;

    typedef enum logic [4:0] {
        S_IN   = 5'b00001,
        S_DIV  = 5'b00010,
        S_FIX  = 5'b00100,
        S_EMIT = 5'b01000,
        S_ENC  = 5'b10000
    } t_state;

    typedef struct packed {
        logic        take;
        logic        start;
        logic        clear;
        logic        fix;
        logic        emit_next;
        logic        enc_next;
    } t_cmd;

    typedef struct packed {
        logic        mode;
        logic        row_done;
        logic        data_done;
        logic        div_done;
        logic        emit_last;
    } t_status;

endpackage

// ----- design/wcrc_datapath.sv -----
module wcrc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [4:0]            i_cfg_data,
    input  logic [63:0]           i_word,
    input  logic                  i_matrix_start,
    input  wcrc_pkg::t_cmd        i_cmd,
    output wcrc_pkg::t_status     o_sts,
    output logic [63:0]           o_word,
    output logic [2:0]            o_status,
    output logic                  o_last,
    output logic [47:0]           o_counts
);
    import wcrc_pkg::*;

    logic              r_mode;
    logic [4:0]        r_width;
    logic [PosW-1:0]   r_pos, n_pos;
    logic [63:0]       r_psum, r_wsum, r_pchk, r_wchk;
    logic [15:0]       r_dcnt, r_ccnt, r_wcnt;
    logic [63:0]       r_mem [MAX_ROW_WIDTH];
    logic [63:0]       r_s1;
    logic [2:0]        r_st;
    logic [2:0]        r_enc;
    logic [63:0]       r_num, r_den, r_rem;
    logic [6:0]        r_dcyc;
    logic              r_dbusy, r_dsame, r_dvd;
    logic [63:0]       r_ew;
    logic [PosW-1:0]   w_eff;
    logic [PosW-1:0]   w_p;
    logic [63:0]       s1, s2, w_rem2, w_mag1, w_mag2;
    logic [64:0]       w_sub;
    logic [63:0]       w_prod;
    logic              w_first;

    always_comb begin
        if (r_width == 5'd0) begin
            w_eff = PosW'(1);
        end else if (int'(r_width) > MAX_ROW_WIDTH) begin
            w_eff = PosW'(MAX_ROW_WIDTH);
        end else begin
            w_eff = PosW'(r_width);
        end
    end

    assign w_p = i_cmd.start ? '0 : r_pos;
    assign w_first = (w_p == '0);
    assign n_pos = w_p + PosW'(1);
    assign w_prod = i_word * 64'(w_p + PosW'(1));
    assign s1 = r_psum - r_pchk;
    assign s2 = r_wsum - i_word;
    assign w_mag1 = s1[63] ? (~s1 + 64'd1) : s1;
    assign w_mag2 = s2[63] ? (~s2 + 64'd1) : s2;
    assign w_rem2 = {r_rem[62:0], r_num[63]};
    assign w_sub = {1'b0, w_rem2} - {1'b0, r_den};

    assign o_sts.mode = r_mode;
    assign o_sts.row_done = (w_p == w_eff + PosW'(1));
    assign o_sts.data_done = (w_p + PosW'(1) >= w_eff);
    assign o_sts.div_done = !r_dbusy;
    assign o_sts.emit_last = (r_pos == w_eff + PosW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_width <= 5'd16;
            r_pos <= '0;
            r_psum <= '0;
            r_wsum <= '0;
            r_pchk <= '0;
            r_dcnt <= '0;
            r_ccnt <= '0;
            r_wcnt <= '0;
            r_dbusy <= 1'b0;
            r_dvd <= 1'b0;
            r_enc <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CfgMode) r_mode <= i_cfg_data[0];
                if (i_cfg_idx == CfgWidth) r_width <= i_cfg_data;
                r_pos <= '0;
                r_psum <= '0;
                r_wsum <= '0;
            end
            if (i_cmd.take) begin
                if (i_matrix_start) begin
                    r_dcnt <= '0;
                    r_ccnt <= '0;
                    r_wcnt <= '0;
                end
                if (!r_mode || w_p < w_eff) begin
                    r_psum <= (w_first ? 64'd0 : r_psum) + i_word;
                    r_wsum <= (w_first ? 64'd0 : r_wsum) + w_prod;
                    if (r_mode) r_mem[w_p[IdxW-1:0]] <= i_word;
                end else if (w_p == w_eff) begin
                    r_pchk <= i_word;
                end else begin
                    r_wchk <= i_word;
                    r_s1 <= s1;
                    r_st <= StClean;
                    r_dvd <= 1'b0;
                    if (s1 != 0 && s2 != 0) begin
                        r_dsame <= (s1[63] == s2[63]);
                        r_num <= w_mag2;
                        r_den <= w_mag1;
                        r_rem <= '0;
                        r_dcyc <= '0;
                        r_dbusy <= 1'b1;
                        r_dvd <= 1'b1;
                    end else if (s2 != 0) begin
                        r_wchk <= r_wsum;
                        r_wcnt <= (r_wcnt == 16'hFFFF) ? r_wcnt : r_wcnt + 16'd1;
                        r_st <= StWeighted;
                    end else if (s1 != 0) begin
                        r_pchk <= r_psum;
                        r_ccnt <= (r_ccnt == 16'hFFFF) ? r_ccnt : r_ccnt + 16'd1;
                        r_st <= StPlain;
                    end
                end
                r_pos <= n_pos;
                if (!r_mode) begin
                    r_ew <= i_word;
                    r_enc <= '0;
                    if (!(w_p + PosW'(1) < w_eff)) r_pos <= '0;
                end else if (w_p == w_eff + PosW'(1)) begin
                    r_pos <= '0;
                end
            end
            if (r_dbusy) begin
                r_num <= {r_num[62:0], !w_sub[64]};
                r_rem <= w_sub[64] ? w_rem2 : w_sub[63:0];
                r_dcyc <= r_dcyc + 7'd1;
                if (r_dcyc == 7'(QBits - 1)) r_dbusy <= 1'b0;
            end
            if (i_cmd.fix && r_dvd) begin
                r_dvd <= 1'b0;
                if (r_dsame && r_num != 0 && r_num <= 64'(w_eff)) begin
                    r_mem[IdxW'(r_num - 64'd1)] <= r_mem[IdxW'(r_num - 64'd1)] - r_s1;
                    r_dcnt <= (r_dcnt == 16'hFFFF) ? r_dcnt : r_dcnt + 16'd1;
                    r_st <= StData;
                end else begin
                    r_st <= StBad;
                end
            end
            if (i_cmd.clear) r_pos <= '0;
            if (i_cmd.emit_next) r_pos <= r_pos + PosW'(1);
            if (i_cmd.enc_next) r_enc <= r_enc + 3'd1;
        end
    end

    always_comb begin
        o_counts = {r_wcnt, r_ccnt, r_dcnt};
        o_last = 1'b0;
        o_status = r_mode ? r_st : StClean;
        o_word = r_ew;
        if (!r_mode) begin
            if (r_enc == 3'd1) o_word = r_psum;
            if (r_enc == 3'd2) begin
                o_word = r_wsum;
                o_last = 1'b1;
            end
        end else begin
            if (r_pos < w_eff) o_word = r_mem[r_pos[IdxW-1:0]];
            else if (r_pos == w_eff) o_word = r_pchk;
            else begin
                o_word = r_wchk;
                o_last = 1'b1;
            end
        end
    end

endmodule

// ----- design/wcrc_ctrl.sv -----
module wcrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_matrix_start,
    input  logic                  i_out_ready,
    input  wcrc_pkg::t_status     i_sts,
    output wcrc_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output logic                  o_enc_tail
);
    import wcrc_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_ecnt;
    logic r_tail;

    assign o_enc_tail = r_tail;
    assign o_in_ready = (r_state == S_IN);
    assign o_out_valid = (r_state == S_EMIT) || (r_state == S_ENC);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_cmd.start = i_matrix_start;
        case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (!i_sts.mode) n_state = S_ENC;
                    else if (i_sts.row_done) n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (i_sts.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IN;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            S_ENC: begin
                if (i_out_ready) begin
                    if (!r_tail || r_ecnt == 2'd2) n_state = S_IN;
                    else o_cmd.enc_next = 1'b1;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_ecnt <= '0;
            r_tail <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.take) begin
                r_ecnt <= '0;
                r_tail <= i_sts.data_done;
            end
            if (o_cmd.enc_next) r_ecnt <= r_ecnt + 2'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while output pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_FIX))
        else $error("bad exit from divide");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |=> (r_state == S_EMIT)) else $error("bad exit from fix");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_next |-> !o_cmd.clear) else $error("emit step and clear");

endmodule

// ----- design/weighted_checksum_row_corrector.sv -----
// Encode mode: one result per data word, plus both checksums after the last data word of a
// row; each word is accepted in S_IN and then presented in S_ENC, where both checksums follow the last.
// Correct mode: a row of W data words and two checksums is taken at one word per cycle, then
// a bit-serial divider finds the error column when both differences are nonzero, S_FIX
// applies the fix, and the W+2 buffered words leave at one per cycle while m_axis_tready is
// high. tdata carries 64-bit words; status and counters travel in tuser, zero-filled to whole
// bytes.
module weighted_checksum_row_corrector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // word
    input  logic        s_axis_tuser,  // matrix_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // out_word
    output logic        m_axis_tlast,
    output logic [55:0] m_axis_tuser   // row_status, data, checksum, weighted counts
);
    import wcrc_pkg::*;

    t_cmd    cmd;
    t_status sts;
    logic    tail;
    logic [2:0] st;
    logic [47:0] cnt;
    logic    lst;

    wcrc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_matrix_start(s_axis_tuser), .i_out_ready(m_axis_tready), .i_sts(sts),
        .o_cmd(cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_enc_tail(tail)
    );

    wcrc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_word(s_axis_tdata), .i_matrix_start(s_axis_tuser),
        .i_cmd(cmd), .o_sts(sts), .o_word(m_axis_tdata), .o_status(st),
        .o_last(lst), .o_counts(cnt)
    );

    assign m_axis_tlast = sts.mode ? lst : (tail && lst);
    assign m_axis_tuser = {5'd0, cnt, st};

endmodule
